FILE: design/mixed_radix_index_split_top_defines.svh
// Assertion macros shared by the mixed radix index split design.
`ifndef MIXED_RADIX_INDEX_SPLIT_TOP_DEFINES_SVH
`define MIXED_RADIX_INDEX_SPLIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset
`define MRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on every clock edge outside reset
`define MRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MRS_ASSERT(lbl, prop, msg)
`define MRS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: design/mrs_pkg.sv
// Types, constants and the divide step shared by the index split design.
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int IDX_W      = 31;
  localparam int LEN_W      = 16;
  localparam int DIMS_W     = 3;
  localparam int HW_DIMS    = 4;
  localparam int NUM_DIV    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (IDX_W + DIV_STEPS - 1) / DIV_STEPS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMS        = 3'd0,
    REG_LEN_SECOND  = 3'd1,
    REG_LEN_THIRD   = 3'd2,
    REG_LEN_FOURTH  = 3'd3
  } reg_idx_e;

  // effective configuration: dimension count and the divisor of each divide pass
  typedef struct packed {
    logic [DIMS_W-1:0]             dims;
    logic [NUM_DIV-1:0][LEN_W-1:0] div;
  } cfg_t;

  // partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [IDX_W-1:0] w;
  } div_acc_t;

  // one restoring division step
  function automatic div_acc_t div_bit(div_acc_t a, logic [LEN_W-1:0] d);
    logic [LEN_W:0] t;
    div_acc_t       r;
    t = {a.rem, a.w[IDX_W-1]};
    if (t >= {1'b0, d}) begin
      r.rem = LEN_W'(t - {1'b0, d});
      r.w   = {a.w[IDX_W-2:0], 1'b1};
    end else begin
      r.rem = t[LEN_W-1:0];
      r.w   = {a.w[IDX_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: design/mrs_cfg_regs.sv
// Configuration registers and derivation of the per-pass divisors.
`timescale 1ns / 1ps
module mrs_cfg_regs #(
  parameter int MAX_DIMS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mrs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mrs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output mrs_pkg::cfg_t                       cfg_o
);

  localparam int DLIM = (MAX_DIMS < mrs_pkg::HW_DIMS) ? MAX_DIMS : mrs_pkg::HW_DIMS;
  localparam logic [mrs_pkg::DIMS_W-1:0] DimsLim = mrs_pkg::DIMS_W'(DLIM);
  localparam logic [mrs_pkg::LEN_W-1:0]  LenOne  = mrs_pkg::LEN_W'(1);

  logic [mrs_pkg::DIMS_W-1:0] dims_q;
  logic [mrs_pkg::LEN_W-1:0]  len2_q, len3_q, len4_q;
  logic [mrs_pkg::DIMS_W-1:0] d;
  logic [mrs_pkg::LEN_W-1:0]  l2, l3, l4;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= mrs_pkg::DIMS_W'(1);
      len2_q <= LenOne;
      len3_q <= LenOne;
      len4_q <= LenOne;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrs_pkg::REG_DIMS:       dims_q <= cfg_wdata_i[mrs_pkg::DIMS_W-1:0];
        mrs_pkg::REG_LEN_SECOND: len2_q <= cfg_wdata_i;
        mrs_pkg::REG_LEN_THIRD:  len3_q <= cfg_wdata_i;
        mrs_pkg::REG_LEN_FOURTH: len4_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // saturated dimension count, zero lengths act as one
  always_comb begin
    d = (dims_q == '0) ? mrs_pkg::DIMS_W'(1) : dims_q;
    if (d > DimsLim) d = DimsLim;
    l2 = (len2_q == '0) ? LenOne : len2_q;
    l3 = (len3_q == '0) ? LenOne : len3_q;
    l4 = (len4_q == '0) ? LenOne : len4_q;
  end

  // passes run from the last active dimension backward
  always_comb begin
    cfg_o.dims   = d;
    cfg_o.div[0] = (d == 3'd4) ? l4 : (d == 3'd3) ? l3 : (d == 3'd2) ? l2 : LenOne;
    cfg_o.div[1] = (d == 3'd4) ? l3 : (d == 3'd3) ? l2 : LenOne;
    cfg_o.div[2] = (d == 3'd4) ? l2 : LenOne;
  end

endmodule

FILE: design/mrs_divider.sv
// Pipelined restoring divider, 31-bit word by 16-bit divisor, with sideband.
`timescale 1ns / 1ps
`include "mixed_radix_index_split_top_defines.svh"
module mrs_divider #(
  parameter int SIDE_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [mrs_pkg::IDX_W-1:0]        dividend_i,
  input  logic [mrs_pkg::LEN_W-1:0]        divisor_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [mrs_pkg::IDX_W-1:0]        quot_o,
  output logic [SIDE_W+mrs_pkg::LEN_W-1:0] side_o
);

  localparam int NSTG = mrs_pkg::DIV_STAGES;

  logic [NSTG-1:0]    vld_q;
  mrs_pkg::div_acc_t  acc_q  [NSTG];
  logic [SIDE_W-1:0]  side_q [NSTG];
  logic [mrs_pkg::LEN_W-1:0] rem_w;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    mrs_pkg::div_acc_t  acc_in, acc_d;
    logic               vin;
    logic [SIDE_W-1:0]  sin;

    if (s == 0) begin : g_first
      assign acc_in = '{rem: '0, w: dividend_i};
      assign vin    = valid_i;
      assign sin    = side_i;
    end else begin : g_next
      assign acc_in = acc_q[s-1];
      assign vin    = vld_q[s-1];
      assign sin    = side_q[s-1];
    end

    // a few quotient bits per stage; the last stage may run short
    always_comb begin
      acc_d = acc_in;
      for (int j = 0; j < mrs_pkg::DIV_STEPS; j++) begin
        if (s * mrs_pkg::DIV_STEPS + j < mrs_pkg::IDX_W) begin
          acc_d = mrs_pkg::div_bit(acc_d, divisor_i);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[s]  <= acc_d;
      side_q[s] <= sin;
    end
  end

  assign rem_w   = acc_q[NSTG-1].rem;
  assign valid_o = vld_q[NSTG-1];
  assign quot_o  = acc_q[NSTG-1].w;
  assign side_o  = {side_q[NSTG-1], rem_w};

  `MRS_ASSERT_IMP(a_latency, valid_i, ##NSTG valid_o, "divider word lost in pipeline")
  `MRS_ASSERT_IMP(a_rem_lt_div, valid_o, rem_w < divisor_i, "remainder not below divisor")
  `MRS_ASSERT_IMP(a_quot_ok, valid_o,
    48'(quot_o) * 48'(divisor_i) + 48'(rem_w) == 48'($past(dividend_i, NSTG)),
    "quotient and remainder do not rebuild dividend")

endmodule

FILE: design/mixed_radix_index_split_top.sv
// Top level: splits a flat row-major index into up to four grid coordinates.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------------
//  input    | flat_index_i                              | start & !busy
//  result   | coord_first_o .. coord_fourth_o           | done_o, one cycle strobe
//  config   | cfg_idx_i, cfg_wdata_i                    | cfg_we_i, no wait
//
// One word enters per cycle; busy is always low. Each word passes through three chained
// pipelined dividers at four quotient bits per stage and then the output register.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module mixed_radix_index_split_top #(
  parameter int MAX_DIMS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [mrs_pkg::IDX_W-1:0]       flat_index_i,
  output logic                            done_o,
  output logic [mrs_pkg::IDX_W-1:0]       coord_first_o,
  output logic [mrs_pkg::LEN_W-1:0]       coord_second_o,
  output logic [mrs_pkg::LEN_W-1:0]       coord_third_o,
  output logic [mrs_pkg::LEN_W-1:0]       coord_fourth_o,
  input  logic                            cfg_we_i,
  input  logic [mrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mrs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int LW = mrs_pkg::LEN_W;

  mrs_pkg::cfg_t             cfg;
  logic                      v0, v1, v2;
  logic [mrs_pkg::IDX_W-1:0] q0, q1, q2;
  logic [LW:0]               s0;
  logic [2*LW:0]             s1;
  logic [3*LW:0]             s2;
  logic [LW-1:0]             r0, r1, r2;

  logic                      done_q;
  logic [mrs_pkg::IDX_W-1:0] first_q;
  logic [LW-1:0]             second_q, third_q, fourth_q;
  logic [LW-1:0]             second_d, third_d, fourth_d;

  assign busy = 1'b0;

  mrs_cfg_regs #(.MAX_DIMS(MAX_DIMS)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .cfg_o(cfg)
  );

  // divide passes from the last active dimension toward the first
  mrs_divider #(.SIDE_W(1)) u_div0 (
    .clk_i, .rst_ni, .valid_i(start), .dividend_i(flat_index_i),
    .divisor_i(cfg.div[0]), .side_i(1'b0), .valid_o(v0), .quot_o(q0), .side_o(s0)
  );
  mrs_divider #(.SIDE_W(LW+1)) u_div1 (
    .clk_i, .rst_ni, .valid_i(v0), .dividend_i(q0),
    .divisor_i(cfg.div[1]), .side_i(s0), .valid_o(v1), .quot_o(q1), .side_o(s1)
  );
  mrs_divider #(.SIDE_W(2*LW+1)) u_div2 (
    .clk_i, .rst_ni, .valid_i(v1), .dividend_i(q1),
    .divisor_i(cfg.div[2]), .side_i(s1), .valid_o(v2), .quot_o(q2), .side_o(s2)
  );

  assign r0 = s2[3*LW-1:2*LW];
  assign r1 = s2[2*LW-1:LW];
  assign r2 = s2[LW-1:0];

  // place remainders on their dimensions
  always_comb begin
    second_d = '0;
    third_d  = '0;
    fourth_d = '0;
    case (cfg.dims)
      3'd4: begin
        second_d = r2;
        third_d  = r1;
        fourth_d = r0;
      end
      3'd3: begin
        second_d = r1;
        third_d  = r0;
      end
      3'd2: begin
        second_d = r0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= q2;
    second_q <= second_d;
    third_q  <= third_d;
    fourth_q <= fourth_d;
  end

  assign done_o         = done_q;
  assign coord_first_o  = first_q;
  assign coord_second_o = second_q;
  assign coord_third_o  = third_q;
  assign coord_fourth_o = fourth_q;

endmodule

FILE: verif/mixed_radix_index_split_top_test.sv
// Testbench for mixed_radix_index_split_top: checks coordinates against an independent predictor.
`timescale 1ns / 1ps
module mixed_radix_index_split_top_test;

  localparam int IW  = mrs_pkg::IDX_W;
  localparam int LW  = mrs_pkg::LEN_W;
  localparam int DW  = mrs_pkg::DIMS_W;
  localparam int CIW = mrs_pkg::CFG_IDX_W;
  localparam int CDW = mrs_pkg::CFG_DATA_W;

  localparam int            HOLD_CYC  = 3 * mrs_pkg::DIV_STAGES + 6;
  localparam logic [CIW-1:0] REG_NONE = 3'd5;
  localparam logic [CIW-1:0] REG_TOP  = 3'd7;

  typedef struct packed {
    logic [IW-1:0] first;
    logic [LW-1:0] second;
    logic [LW-1:0] third;
    logic [LW-1:0] fourth;
  } coord_set_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [IW-1:0]   flat_index_i = '0;
  logic            done_o;
  logic [IW-1:0]   coord_first_o;
  logic [LW-1:0]   coord_second_o, coord_third_o, coord_fourth_o;
  logic            cfg_we_i = 1'b0;
  logic [CIW-1:0]  cfg_idx_i = '0;
  logic [CDW-1:0]  cfg_wdata_i = '0;

  // shadow of the grid shape registers
  logic [DW-1:0]   grid_dims = 3'd1;
  logic [LW-1:0]   grid_len[1:3] = '{16'd1, 16'd1, 16'd1};

  logic [IW-1:0]   index_fifo[$];
  coord_set_t      coord_fifo[$];
  int              gap_cnt = 0;
  logic            burst = 1'b0;
  logic            taken = 1'b0;
  int              err_cnt = 0;
  int              word_cnt = 0;
  int              cfg_cnt = 0;

  mixed_radix_index_split_top DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // expected coordinates for one index under the current grid shape
  function automatic coord_set_t split_index(logic [IW-1:0] idx);
    longint unsigned lens[4];
    longint unsigned coord[4];
    longint unsigned rem, divisor;
    int unsigned     nd;
    coord_set_t      c;
    nd = 32'(grid_dims);
    if (nd < 1) nd = 1;
    if (nd > 4) nd = 4;
    lens[0] = 64'd1;
    for (int i = 1; i < 4; i++) lens[i] = (grid_len[i] == '0) ? 64'd1 : 64'(grid_len[i]);
    for (int i = 0; i < 4; i++) coord[i] = 64'd0;
    rem = 64'(idx);
    divisor = 64'd1;
    for (int i = 1; i < nd; i++) divisor *= lens[i];
    for (int i = 0; i + 1 < nd; i++) begin
      coord[i] = rem / divisor;
      rem = rem % divisor;
      divisor = divisor / lens[i+1];
    end
    coord[nd-1] = rem;
    c.first  = coord[0][IW-1:0];
    c.second = coord[1][LW-1:0];
    c.third  = coord[2][LW-1:0];
    c.fourth = coord[3][LW-1:0];
    return c;
  endfunction

  task automatic report(string what, logic [IW-1:0] got, logic [IW-1:0] want);
    err_cnt++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // register write, one cycle of enable
  task automatic write_reg(logic [CIW-1:0] idx, logic [CDW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      mrs_pkg::REG_DIMS:       grid_dims   = data[DW-1:0];
      mrs_pkg::REG_LEN_SECOND: grid_len[1] = data;
      mrs_pkg::REG_LEN_THIRD:  grid_len[2] = data;
      mrs_pkg::REG_LEN_FOURTH: grid_len[3] = data;
      default: ;
    endcase
    cfg_cnt++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(logic [2:0] d, logic [15:0] l2, logic [15:0] l3, logic [15:0] l4);
    write_reg(mrs_pkg::REG_DIMS, {13'd0, d});
    write_reg(mrs_pkg::REG_LEN_SECOND, l2);
    write_reg(mrs_pkg::REG_LEN_THIRD, l3);
    write_reg(mrs_pkg::REG_LEN_FOURTH, l4);
  endtask

  // hold off until every word has come back and the pipeline has drained
  task automatic drain();
    while (index_fifo.size() != 0 || start || coord_fifo.size() != 0) @(posedge clk_i);
    repeat (HOLD_CYC) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(2, 12));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IW-1:0] pick_index();
    case ($urandom_range(0, 3))
      0: return IW'($urandom_range(0, 4095));
      1: return IW'({$urandom} | 32'h4000_0000);
      default: return IW'($urandom);
    endcase
  endfunction

  // driver: holds start until the word is taken, then waits a drawn gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (gap_cnt > 0) begin
      gap_cnt <= gap_cnt - 1;
      start   <= 1'b0;
    end else if (index_fifo.size() != 0) begin
      start        <= 1'b1;
      flat_index_i <= index_fifo.pop_front();
      gap_cnt      <= burst ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 39) == 0) burst <= !burst;
    end else begin
      start <= 1'b0;
    end
  end

  // acceptance and result check
  always @(posedge clk_i) begin
    coord_set_t want;
    taken <= start && !busy;
    if (rst_ni && start && !busy) begin
      coord_fifo = {coord_fifo, split_index(flat_index_i)};
      word_cnt++;
    end
    if (rst_ni && done_o) begin
      if (coord_fifo.size() == 0) begin
        report("unexpected word", coord_first_o, '0);
      end else begin
        want = coord_fifo.pop_front();
        if (coord_first_o !== want.first)   report("coord_first", coord_first_o, want.first);
        if (coord_second_o !== want.second) begin
          report("coord_second", IW'(coord_second_o), IW'(want.second));
        end
        if (coord_third_o !== want.third) begin
          report("coord_third", IW'(coord_third_o), IW'(want.third));
        end
        if (coord_fourth_o !== want.fourth) begin
          report("coord_fourth", IW'(coord_fourth_o), IW'(want.fourth));
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset shape: one dimension, index passes straight through
    index_fifo = '{31'd0, 31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA};
    drain();
    // four dimensions at full length
    set_grid(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    index_fifo = '{31'd0, 31'h7FFF_FFFF, 31'd65534, 31'd65535, 31'h1234_5678};
    drain();
    // zero dimensions acts as one
    write_reg(mrs_pkg::REG_DIMS, 16'd0);
    index_fifo = '{31'd12345, 31'h7FFF_FFFF};
    drain();
    // too many dimensions saturates, zero lengths act as one
    set_grid(3'd7, 16'd0, 16'd7, 16'd0);
    index_fifo = '{31'd100, 31'h7FFF_FFFF};
    drain();
    // two and three dimensions, unused lengths ignored, unknown index dropped
    set_grid(3'd2, 16'd10, 16'd3, 16'd9);
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(REG_TOP, 16'h0001);
    index_fifo = '{31'd0, 31'd9, 31'd10, 31'd99, 31'h7FFF_FFFF};
    drain();
    set_grid(3'd3, 16'd1, 16'd5, 16'hFFFF);
    index_fifo = '{31'd4, 31'd5, 31'h7FFF_FFFF};
    drain();

    // random shapes and indexes
    for (int ph = 0; ph < 11; ph++) begin
      set_grid(3'($urandom_range(0, 7)), pick_len(), pick_len(), pick_len());
      if ($urandom_range(0, 3) == 0) write_reg(CIW'($urandom_range(4, 7)), 16'($urandom));
      for (int n = 0; n < 100; n++) index_fifo = {index_fifo, pick_index()};
      drain();
    end

    $display("covered %0d words over %0d register writes, dims 0..7 and lengths 0..65535",
             word_cnt, cfg_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
